>>> design/pcfd_pkg.sv
package pcfd_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_KP      = 3'd0;
    localparam logic [2:0] REG_KI      = 3'd1;
    localparam logic [2:0] REG_KD      = 3'd2;
    localparam logic [2:0] REG_TAU     = 3'd3;
    localparam logic [2:0] REG_LO_LIM  = 3'd4;
    localparam logic [2:0] REG_HI_LIM  = 3'd5;
    localparam logic [2:0] REG_INT_EN  = 3'd6;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 68;
    localparam int WIDE_W = 52;
    localparam int DIV_W  = 33;

    typedef logic signed [31:0]     q_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Saturates a wide signed value to 32 bits.
    function automatic q_t sat_wide(input wide_t v);
        if (v[WIDE_W-1:31] == {(WIDE_W-31){v[WIDE_W-1]}})
            return v[31:0];
        else
            return v[WIDE_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    // Round to nearest, ties toward plus infinity, dropping 16 fraction bits.
    function automatic wide_t rnd16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + 68'sd32768;
        return s[PROD_W-1:16];
    endfunction

endpackage

>>> design/pcfd_mul.sv
module pcfd_mul
    import pcfd_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod_reg
);

    // One registered signed multiplication per cycle.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

>>> design/pcfd_div.sv
module pcfd_div
    import pcfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctrl_t        ctrl,
    input  wide_t            num,
    input  logic [DIV_W-1:0] divisor,
    output div_stat_t        stat,
    output q_t               quot
);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic             ovf_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [31:0]      low_reg;
    logic [31:0]      q_reg;
    logic [4:0]       cnt_reg;
    logic [DIV_W-1:0] dvs_reg;

    logic [WIDE_W-1:0] mag;
    logic [DIV_W:0]    trial;
    logic              fits;

    assign mag   = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
    assign trial = {rem_reg, low_reg[31]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // Restoring division of |num| * 2^16 by the divisor, one quotient bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            neg_reg <= num[WIDE_W-1];
            ovf_reg <= mag >= {3'b000, divisor, 16'h0000};
            rem_reg <= mag[DIV_W+15:16];
            low_reg <= {mag[15:0], 16'h0000};
            dvs_reg <= divisor;
            cnt_reg <= 5'd31;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
            low_reg <= {low_reg[30:0], 1'b0};
            q_reg   <= {q_reg[30:0], fits};
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_comb
    begin
        if (ovf_reg)
            quot = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (neg_reg)
            quot = (q_reg > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(q_reg);
        else
            quot = (q_reg > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q_reg);
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> design/pid_controller_filtered_derivative_core.sv
// PID controller with a trapezoidal integrator and a low-pass filtered derivative on
// the measurement, all in signed Q16.16. Each input item (setpoint, measurement, time
// step, restart flag) yields exactly one drive value item. The block handles one item
// at a time and holds in_stall high while it works. For a normal item, eight steps of
// a small sequencer share one registered 34 by 34 bit multiplier for the proportional,
// integral and derivative products, and the filter division then runs one quotient bit
// per cycle in a restoring divider that reports completion when it is done. When the
// filter divisor is zero the division is skipped. A restart item returns 0.
// The result sits in an output register, so the next item is accepted while the
// previous result still waits to be taken. Configuration registers are written through
// cfg_write, cfg_index and cfg_data and must only be changed while the block is idle.
module pid_controller_filtered_derivative_core
    import pcfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] target_value,
    input  logic signed [31:0] measured_value,
    input  logic [15:0]        time_step,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] drive_value
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_MP   = 4'd2;
    localparam logic [3:0] S_MT   = 4'd3;
    localparam logic [3:0] S_BND  = 4'd4;
    localparam logic [3:0] S_MI   = 4'd5;
    localparam logic [3:0] S_MF   = 4'd6;
    localparam logic [3:0] S_CLMP = 4'd7;
    localparam logic [3:0] S_DST  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_SUM  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    // Configuration registers.
    q_t          kp_reg;
    q_t          ki_reg;
    q_t          kd_reg;
    logic [30:0] tau_reg;
    q_t          lo_lim_reg;
    q_t          hi_lim_reg;
    logic        int_en_reg;

    // Controller state carried from item to item.
    q_t integral_reg;
    q_t slope_reg;
    q_t last_err_reg;
    q_t last_meas_reg;

    // Sequencer and working registers.
    logic [3:0]              state_reg;
    logic [3:0]              state_next;
    q_t                      tgt_reg;
    q_t                      meas_reg;
    logic [15:0]             dt_reg;
    q_t                      err_reg;
    logic signed [32:0]      esum_reg;
    logic signed [32:0]      dm_reg;
    logic [DIV_W-1:0]        divisor_reg;
    logic signed [MUL_W-1:0] tmd_reg;
    q_t                      prop_reg;
    q_t                      hi_reg;
    q_t                      lo_reg;
    logic signed [32:0]      t_reg;
    wide_t                   t1_reg;
    wide_t                   acc_reg;
    wide_t                   num_reg;
    q_t                      result_reg;
    logic                    out_valid_reg;
    q_t                      drive_reg;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    div_ctrl_t                div_ctrl;
    div_stat_t                div_stat;
    q_t                       div_quot;

    logic signed [32:0]  err_raw;
    q_t                  err_sat;
    logic signed [32:0]  hi_diff;
    logic signed [32:0]  lo_diff;
    wide_t               rnd_prod;
    logic signed [PROD_W-1:0] inc_sum;
    q_t                  slope_val;
    logic signed [33:0]  total;
    q_t                  total_sat;
    q_t                  clamped;
    logic                in_accept;
    logic                out_free;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign drive_value = drive_reg;

    assign err_raw = {tgt_reg[31], tgt_reg} - {meas_reg[31], meas_reg};
    assign err_sat = (err_raw[32] == err_raw[31]) ? err_raw[31:0]
                   : (err_raw[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    assign rnd_prod = rnd16(prod_reg);
    assign inc_sum  = prod_reg + 68'sd65536;

    assign hi_diff = {hi_lim_reg[31], hi_lim_reg} - {prop_reg[31], prop_reg};
    assign lo_diff = {lo_lim_reg[31], lo_lim_reg} - {prop_reg[31], prop_reg};

    assign slope_val = (divisor_reg == '0) ? 32'sd0 : div_quot;
    assign total     = 34'(prop_reg) + 34'(integral_reg) + 34'(slope_val);
    assign total_sat = sat_wide(WIDE_W'(total));

    always_comb
    begin
        clamped = total_sat;
        if (clamped > hi_lim_reg)
            clamped = hi_lim_reg;
        if (clamped < lo_lim_reg)
            clamped = lo_lim_reg;
    end

    // The shared multiplier takes its operands from the sequencer step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MP:
            begin
                mul_a = MUL_W'(kp_reg);
                mul_b = MUL_W'(err_reg);
            end
            S_MT:
            begin
                mul_a = MUL_W'(ki_reg);
                mul_b = $signed({18'b0, dt_reg});
            end
            S_BND:
            begin
                mul_a = MUL_W'(kd_reg);
                mul_b = MUL_W'(dm_reg);
            end
            S_MI:
            begin
                mul_a = MUL_W'(t_reg);
                mul_b = MUL_W'(esum_reg);
            end
            S_MF:
            begin
                mul_a = tmd_reg;
                mul_b = MUL_W'(slope_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_ctrl.start = (state_reg == S_DST) && (divisor_reg != '0);

    pcfd_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    pcfd_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (div_ctrl),
        .num     (num_reg),
        .divisor (divisor_reg),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = restart ? S_OUT : S_PREP;
            S_PREP: state_next = S_MP;
            S_MP:   state_next = S_MT;
            S_MT:   state_next = S_BND;
            S_BND:  state_next = S_MI;
            S_MI:   state_next = S_MF;
            S_MF:   state_next = S_CLMP;
            S_CLMP: state_next = S_DST;
            S_DST:  state_next = (divisor_reg == '0) ? S_SUM : S_DIV;
            S_DIV:  if (div_stat.done) state_next = S_SUM;
            S_SUM:  state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            tau_reg       <= '0;
            lo_lim_reg    <= -32'sd65536;
            hi_lim_reg    <= 32'sd65536;
            int_en_reg    <= 1'b1;
            integral_reg  <= '0;
            slope_reg     <= '0;
            last_err_reg  <= '0;
            last_meas_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_KP:     kp_reg     <= cfg_data;
                    REG_KI:     ki_reg     <= cfg_data;
                    REG_KD:     kd_reg     <= cfg_data;
                    REG_TAU:    tau_reg    <= cfg_data[30:0];
                    REG_LO_LIM: lo_lim_reg <= cfg_data;
                    REG_HI_LIM: hi_lim_reg <= cfg_data;
                    REG_INT_EN: int_en_reg <= cfg_data[0];
                    default:    ;
                endcase
            end

            if (in_accept && restart)
            begin
                integral_reg <= '0;
                slope_reg    <= '0;
            end

            if (state_reg == S_CLMP)
            begin
                if (!int_en_reg)
                    integral_reg <= '0;
                else if (acc_reg < WIDE_W'(lo_reg))
                    integral_reg <= lo_reg;
                else if (acc_reg > WIDE_W'(hi_reg))
                    integral_reg <= hi_reg;
                else
                    integral_reg <= acc_reg[31:0];
            end

            if (state_reg == S_SUM)
                slope_reg <= slope_val;

            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                last_err_reg  <= err_reg;
                last_meas_reg <= meas_reg;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            tgt_reg  <= target_value;
            meas_reg <= restart ? 32'sd0 : measured_value;
            dt_reg   <= time_step;
            if (restart)
            begin
                err_reg    <= '0;
                result_reg <= '0;
            end
        end

        case (state_reg)
            S_PREP:
            begin
                err_reg     <= err_sat;
                esum_reg    <= 33'(err_sat) + 33'(last_err_reg);
                dm_reg      <= {meas_reg[31], meas_reg} - {last_meas_reg[31], last_meas_reg};
                divisor_reg <= {1'b0, tau_reg, 1'b0} + {17'b0, dt_reg};
                tmd_reg     <= $signed({2'b00, tau_reg, 1'b0}) - $signed({18'b0, dt_reg});
            end
            S_MT:
            begin
                prop_reg <= sat_wide(rnd_prod);
            end
            S_BND:
            begin
                t_reg <= rnd_prod[32:0];
                if (hi_diff[32])
                    hi_reg <= '0;
                else if (hi_diff[31])
                    hi_reg <= 32'sh7FFF_FFFF;
                else
                    hi_reg <= hi_diff[31:0];
                if (!lo_diff[32])
                    lo_reg <= '0;
                else if (!lo_diff[31])
                    lo_reg <= 32'sh8000_0000;
                else
                    lo_reg <= lo_diff[31:0];
            end
            S_MI:
            begin
                t1_reg <= rnd_prod;
            end
            S_MF:
            begin
                acc_reg <= WIDE_W'(integral_reg) + WIDE_W'($signed(inc_sum[PROD_W-1:17]));
            end
            S_CLMP:
            begin
                num_reg <= rnd_prod - (t1_reg <<< 1);
            end
            S_SUM:
            begin
                result_reg <= clamped;
            end
            default:
            begin
            end
        endcase

        if (state_reg == S_OUT && out_free)
            drive_reg <= result_reg;
    end

`ifndef SYNTHESIS
    a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == S_DIV))
        else $error("divider running outside the divide step");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

    a_int_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLMP && int_en_reg)
        |=> (integral_reg <= hi_reg) && (integral_reg >= lo_reg))
        else $error("integrator left its dynamic bounds");

    a_int_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLMP && !int_en_reg) |=> (integral_reg == 32'sd0))
        else $error("disabled integrator not held at zero");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result offered without passing the output step");
`endif

endmodule

>>> verif/pcfd_checker.sv
`timescale 1ns / 100ps

// Watches the configuration port and both item channels, keeps its own model of the
// controller state and compares every drive value with the oldest prediction.
module pcfd_checker
    import pcfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] target_value,
    input  logic signed [31:0] measured_value,
    input  logic [15:0]        time_step,
    input  logic               restart,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] drive_value,
    output int                 errors,
    output int                 drives_waiting,
    output int                 drives_seen
);

    // Shadow of the configuration registers.
    logic signed [31:0] kp, ki, kd, lo_lim, hi_lim;
    longint             tau;
    logic               int_en;

    // Shadow of the controller state.
    logic signed [31:0] integ, slope, prev_err, prev_meas;

    logic signed [31:0] drive_q[$];

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint round_q16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] predict_drive(input logic signed [31:0] tgt,
                                                        input logic signed [31:0] meas,
                                                        input logic [15:0] dt_in,
                                                        input logic rs);
        longint dt, err, prop, hi_b, lo_b, t, inc, acc, dv, t1, t2, num, q, r;
        logic signed [31:0] res;
        dt = longint'(dt_in);
        if (rs)
        begin
            integ = 0;
            slope = 0;
            prev_err = 0;
            prev_meas = 0;
            return 0;
        end
        err  = sat32(longint'(tgt) - longint'(meas));
        prop = sat32(round_q16(longint'(kp) * err));
        hi_b = longint'(hi_lim) - prop;
        if (hi_b < 0)
            hi_b = 0;
        hi_b = sat32(hi_b);
        lo_b = longint'(lo_lim) - prop;
        if (lo_b > 0)
            lo_b = 0;
        lo_b = sat32(lo_b);
        if (int_en)
        begin
            t   = round_q16(longint'(ki) * dt);
            inc = (t * (err + longint'(prev_err)) + 65536) >>> 17;
            acc = longint'(integ) + inc;
            if (acc < lo_b)
                acc = lo_b;
            if (acc > hi_b)
                acc = hi_b;
            integ = acc[31:0];
        end
        else
            integ = 0;
        dv = 2 * tau + dt;
        if (dv == 0)
            slope = 0;
        else
        begin
            t1  = round_q16(longint'(kd) * (longint'(meas) - longint'(prev_meas)));
            t2  = round_q16((2 * tau - dt) * longint'(slope));
            num = -2 * t1 + t2;
            q   = num / dv;
            r   = num % dv;
            if (q > 64'sd2147483647)
                slope = 32'sh7FFF_FFFF;
            else if (q < -64'sd2147483648)
                slope = 32'sh8000_0000;
            else
                slope = sat32(q * 65536 + (r * 65536) / dv);
        end
        res = sat32(prop + longint'(integ) + longint'(slope));
        if (res > hi_lim)
            res = hi_lim;
        if (res < lo_lim)
            res = lo_lim;
        prev_err  = err[31:0];
        prev_meas = meas;
        return res;
    endfunction

    assign drives_waiting = drive_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [31:0] want;
        if (!rst_n)
        begin
            kp = 0; ki = 0; kd = 0; tau = 0;
            lo_lim = -32'sd65536; hi_lim = 32'sd65536; int_en = 1'b1;
            integ = 0; slope = 0; prev_err = 0; prev_meas = 0;
            drive_q.delete();
            errors = 0;
            drives_seen = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                drives_seen++;
                if (drive_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: drive value %0d with no item outstanding",
                                 $realtime, drive_value);
                    errors++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (drive_value !== want)
                    begin
                        if (errors < 10)
                            $display("%0t: drive_value expected %0d got %0d",
                                     $realtime, want, drive_value);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                drive_q.push_back(predict_drive(target_value, measured_value,
                                                time_step, restart));
            if (cfg_write)
                case (cfg_index)
                    REG_KP:     kp = cfg_data;
                    REG_KI:     ki = cfg_data;
                    REG_KD:     kd = cfg_data;
                    REG_TAU:    tau = longint'(cfg_data[30:0]);
                    REG_LO_LIM: lo_lim = cfg_data;
                    REG_HI_LIM: hi_lim = cfg_data;
                    REG_INT_EN: int_en = cfg_data[0];
                    default:    ;
                endcase
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

// Top of the bench. It makes the stimulus for the PID core, runs the configuration
// phases and gives the verdict; all prediction and comparison sits in the checker.
module testbench
    import pcfd_pkg::*;
();

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] target_value;
    logic signed [31:0] measured_value;
    logic [15:0]        time_step;
    logic               restart;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] drive_value;

    int errors;
    int drives_waiting;
    int drives_seen;
    int items_sent;
    int restarts_sent;
    int idle_cycles;
    int stall_mode;

    // Cycles with no item moving on either channel before the run is abandoned. This
    // leaves a wide margin over the processing of one item for stalls and pauses.
    localparam int WATCHDOG_LIMIT = 5000;

    pid_controller_filtered_derivative_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .target_value   (target_value),
        .measured_value (measured_value),
        .time_step      (time_step),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive_value    (drive_value)
    );

    pcfd_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .target_value   (target_value),
        .measured_value (measured_value),
        .time_step      (time_step),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive_value    (drive_value),
        .errors         (errors),
        .drives_waiting (drives_waiting),
        .drives_seen    (drives_seen)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // The receiver changes its stall habit at random: sometimes it never stalls,
    // sometimes lightly and sometimes heavily, so stalls land on every phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 299) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 9) < 3);
                default: out_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    // The watchdog only counts cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d drive values outstanding", drives_waiting);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // Writes the full register set, then lowers the write enable.
    task automatic set_config(input logic [31:0] p, input logic [31:0] i,
                              input logic [31:0] d, input logic [31:0] tc,
                              input logic [31:0] lo, input logic [31:0] hi,
                              input logic en);
        write_reg(REG_KP, p);
        write_reg(REG_KI, i);
        write_reg(REG_KD, d);
        write_reg(REG_TAU, tc);
        write_reg(REG_LO_LIM, lo);
        write_reg(REG_HI_LIM, hi);
        write_reg(REG_INT_EN, {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0, en});
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Holds the item on the channel until the block takes it. Valid is left high so
    // that a following item goes out back to back; a gap lowers it explicitly.
    task automatic send_item(input logic signed [31:0] tgt, input logic signed [31:0] meas,
                             input logic [15:0] dt, input logic rs);
        target_value   <= tgt;
        measured_value <= meas;
        time_step      <= dt;
        restart        <= rs;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (rs)
            restarts_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Waits until every drive value has been taken, then lets the core settle.
    task automatic drain;
        pause_sender(1);
        while (drives_waiting != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Most values stay within a few units so that the loop does not sit at the limits;
    // the rest are anywhere in the 32 bit range or at the extremes.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return $urandom_range(0, 65535);
            default: return $urandom_range(16, 2048);
        endcase
    endfunction

    // Random items in bursts of random length. A burst is mostly an ordinary run of
    // measurements; the occasional restart flag breaks the sequence.
    task automatic random_items(input int count);
        int burst;
        int n;
        logic signed [31:0] sp;
        logic signed [31:0] pv;
        n = 0;
        sp = pick_value();
        pv = pick_value();
        while (n < count)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                if ($urandom_range(0, 7) == 0)
                    sp = pick_value();
                if ($urandom_range(0, 3) == 0)
                    pv = pick_value();
                else
                    pv = pv + $signed($urandom_range(0, 8191)) - 4096;
                send_item(sp, pv, pick_step(), $urandom_range(0, 29) == 0);
                n++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 60));
        end
    endtask

    function automatic logic [31:0] small_gain();
        return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endfunction

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = REG_KP;
        cfg_data       = 32'd0;
        in_valid       = 1'b0;
        target_value   = 32'sd0;
        measured_value = 32'sd0;
        time_step      = 16'd0;
        restart        = 1'b0;
        items_sent     = 0;
        restarts_sent  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items, first with the reset configuration: field extremes, a
        // restart, and a zero time step with zero tau, which zeroes the derivative.
        send_item(32'sd0, 32'sd0, 16'd0, 1'b0);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 1'b0);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
        send_item(32'sd65536, -32'sd65536, 16'd0, 1'b0);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h8000, 1'b1);
        drain();

        // Large gains, maximum tau and a write to the unused register index.
        set_config(32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'h7FFF_FFFF,
                   32'hFFFE_0000, 32'h0002_0000, 1'b1);
        write_reg(3'd7, 32'hFFFF_FFFF);
        @(posedge clk);
        cfg_write <= 1'b0;
        send_item(32'sd65536, 32'sd0, 16'd1000, 1'b0);
        send_item(32'sd65536, 32'sd0, 16'd1000, 1'b0);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
        send_item(32'sd0, 32'sd12345, 16'd0, 1'b0);
        drain();

        // Extreme gains of both signs with the widest limits.
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                   32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 1'b0);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
        send_item(32'sd3, -32'sd3, 16'd0, 1'b0);
        drain();

        // Integrator disabled and crossed limits: apart from the restart item, the output must sit on the lower one.
        set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                   32'h0001_0000, 32'hFFFF_0000, 1'b0);
        send_item(32'sd100, 32'sd0, 16'd100, 1'b0);
        send_item(-32'sd100, 32'sd50, 16'd0, 1'b0);
        send_item(32'sd0, 32'sd0, 16'd1, 1'b1);
        drain();

        // Random phases, each under its own setting, with a full drain between them.
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase % 4)
                0: set_config(small_gain(), small_gain(), small_gain(),
                              $urandom_range(0, 32'h0002_0000),
                              32'hFFFF_0000 - $urandom_range(0, 32'h0004_0000),
                              32'h0001_0000 + $urandom_range(0, 32'h0004_0000), 1'b1);
                1: set_config(small_gain(), small_gain(), small_gain(),
                              $urandom_range(0, 3) == 0 ? 32'd0 : $urandom(),
                              32'hFFF0_0000, 32'h0010_0000, $urandom_range(0, 1));
                2: set_config($urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom(), $urandom_range(0, 1));
                default: set_config(small_gain(), small_gain(), small_gain(), 32'd0,
                                    32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
            endcase
            random_items(130);
            drain();
        end

        // Back to the reset values of every register.
        set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_0000, 32'h0001_0000, 1'b1);
        send_item(32'sd65536, 32'sd0, 16'd100, 1'b0);
        drain();
        repeat (100) @(posedge clk);

        $display("Sent %0d items (%0d restarts) over 15 register settings, %0d drive values",
                 items_sent, restarts_sent, drives_seen);
        $display("checked, %0d mismatches", errors);
        if (errors == 0 && drives_waiting == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
design/pcfd_pkg.sv
design/pcfd_mul.sv
design/pcfd_div.sv
design/pid_controller_filtered_derivative_core.sv
verif/pcfd_checker.sv
verif/testbench.sv
